/* design/elot_pkg.sv */
// shared types and constants for the engine lease ownership tracker
package elot_pkg;

  localparam int unsigned Engines  = 4;
  localparam int unsigned IxW      = 2;
  localparam int unsigned GenW     = 32;
  localparam int unsigned OwnerW   = 32;
  localparam int unsigned KindW    = 3;
  localparam int unsigned InDataW  = 168;
  localparam int unsigned OutDataW = 104;

  localparam logic [23:0] TokMagic  = 24'hA54D;
  localparam logic [31:0] Ver1Exact = 32'h0000_0202;
  localparam logic [31:0] Ver2Mask  = 32'hFFFF_FFF0;
  localparam logic [31:0] Ver2Value = 32'h0225_2700;
  localparam logic [7:0]  Ver4LoA   = 8'h53;
  localparam logic [7:0]  Ver4LoB   = 8'h54;

  // operation codes carried on in_tuser
  typedef enum logic [KindW-1:0] {
    K_IDENT    = 3'd0,
    K_ACQUIRE  = 3'd1,
    K_COMPLETE = 3'd2,
    K_RELEASE  = 3'd3,
    K_ABORT    = 3'd4,
    K_QUERY    = 3'd5,
    K_REARM    = 3'd6,
    K_READ     = 3'd7
  } kind_t;

  // per-engine ownership record state
  typedef enum logic [2:0] {
    ST_DISABLED = 3'd0,
    ST_IDENT    = 3'd1,
    ST_LEASED   = 3'd2,
    ST_DONE     = 3'd3,
    ST_RELEASED = 3'd4,
    ST_QUAR     = 3'd5
  } eng_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } elot_cmd_t;

endpackage

/* design/elot_ctrl.sv */
// handshake controller: one item in flight, result held in an output register
module elot_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output elot_pkg::elot_cmd_t cmd
);
  import elot_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctrl_state_t;

  ctrl_state_t state_r;
  logic        in_tready_r;
  logic        out_valid_r;
  logic        accept;
  logic        out_free;

  assign accept     = in_tvalid && in_tready_r;
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = in_tready_r;
  assign out_tvalid = out_valid_r;

  // commands to the datapath
  always_comb begin
    cmd.capture = accept;
    cmd.commit  = (state_r == S_EXEC) && out_free;
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (out_tready) out_valid_r <= 1'b0;
          if (accept) begin
            in_tready_r <= 1'b0;
            state_r     <= S_EXEC;
          end else begin
            // open the input once reset has been released
            in_tready_r <= 1'b1;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            in_tready_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/elot_dp.sv */
// datapath: engine records, shared slot, lease checks and result register
module elot_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  elot_pkg::elot_cmd_t           cmd,
  input  logic [elot_pkg::KindW-1:0]    in_tuser,
  input  logic [elot_pkg::InDataW-1:0]  in_tdata,
  input  logic                          cfg_we,
  input  logic [elot_pkg::OwnerW-1:0]   cfg_wdata,
  output logic [elot_pkg::OutDataW-1:0] out_tdata
);
  import elot_pkg::*;

  // captured input beat
  kind_t        kind_r;
  logic [7:0]   eng_r;
  logic [31:0]  ver_r;
  logic [63:0]  tok_r;
  logic [31:0]  own_r;
  logic [31:0]  rsv_r;

  // configuration and records
  logic [OwnerW-1:0] owner_id_r;
  eng_state_t        st_r      [Engines];
  logic [GenW-1:0]   eng_gen_r [Engines];
  logic [GenW-1:0]   lease_gen_r [Engines];
  logic [31:0]       id_ver_r  [Engines];
  logic [2:0]        slot_eng_r;
  logic [GenW-1:0]   slot_gen_r;

  // result register
  logic         ok_r;
  logic [63:0]  tok_out_r;
  logic [31:0]  own_out_r;
  logic [2:0]   st_out_r;

  // decode
  logic          eng_valid;
  logic [IxW-1:0] ix;
  logic [7:0]    tok_eng;
  logic [GenW-1:0] tok_gen;
  logic [IxW-1:0] lix;
  logic          le_ok;
  logic          ver_ok;

  // actions
  logic [IxW-1:0] act_ix;
  logic           wr_st;
  eng_state_t     new_st;
  logic           do_bump;
  logic           do_clr_ver;
  logic           do_set_ver;
  logic           do_acq;
  logic           do_drop;
  logic           ok_c;
  logic [63:0]    tok_c;
  logic [31:0]    own_c;
  logic [2:0]     st_c;
  logic [GenW-1:0] gen_inc;

  assign eng_valid = (eng_r >= 8'd1) && (eng_r <= 8'(Engines));
  assign ix        = eng_r[IxW-1:0] - IxW'(1);
  assign tok_eng   = tok_r[7:0];
  assign tok_gen   = tok_r[39:8];
  assign lix       = tok_eng[IxW-1:0] - IxW'(1);

  // presented lease check
  assign le_ok = (own_r != '0) && (own_r == owner_id_r) && (rsv_r == '0) &&
                 (tok_r[63:40] == TokMagic) &&
                 (tok_eng >= 8'd1) && (tok_eng <= 8'(Engines)) &&
                 (tok_gen != '0) && (eng_gen_r[lix] == tok_gen) &&
                 (lease_gen_r[lix] == tok_gen);

  // fixed per-engine version rules; engine 3 never matches
  always_comb begin
    unique case (eng_r)
      8'd1:    ver_ok = (ver_r == Ver1Exact);
      8'd2:    ver_ok = ((ver_r & Ver2Mask) == Ver2Value);
      8'd4:    ver_ok = (ver_r[7:0] == Ver4LoA) || (ver_r[7:0] == Ver4LoB);
      default: ver_ok = 1'b0;
    endcase
  end

  // operation decode
  always_comb begin
    act_ix     = ix;
    wr_st      = 1'b0;
    new_st     = ST_DISABLED;
    do_bump    = 1'b0;
    do_clr_ver = 1'b0;
    do_set_ver = 1'b0;
    do_acq     = 1'b0;
    do_drop    = 1'b0;
    ok_c       = 1'b0;
    tok_c      = '0;
    own_c      = '0;
    st_c       = '0;
    unique case (kind_r)
      K_IDENT: begin
        if (eng_valid && (eng_r != 8'd3) &&
            ((st_r[ix] == ST_DISABLED) || (st_r[ix] == ST_RELEASED))) begin
          wr_st = 1'b1;
          if (ver_ok) begin
            new_st     = ST_IDENT;
            do_set_ver = 1'b1;
            ok_c       = 1'b1;
          end else begin
            new_st     = ST_QUAR;
            do_clr_ver = 1'b1;
            do_bump    = 1'b1;
          end
        end
      end
      K_ACQUIRE: begin
        if (((eng_r == 8'd1) || (eng_r == 8'd2)) && (st_r[ix] == ST_IDENT) &&
            (slot_eng_r == '0)) begin
          wr_st  = 1'b1;
          new_st = ST_LEASED;
          do_acq = 1'b1;
          ok_c   = 1'b1;
          tok_c  = {TokMagic, eng_gen_r[ix], eng_r};
          own_c  = owner_id_r;
        end
      end
      K_COMPLETE: begin
        act_ix = lix;
        if (le_ok && (st_r[lix] == ST_LEASED)) begin
          wr_st  = 1'b1;
          new_st = ST_DONE;
          ok_c   = 1'b1;
        end
      end
      K_RELEASE: begin
        act_ix = lix;
        if (le_ok && (st_r[lix] == ST_DONE)) begin
          wr_st      = 1'b1;
          new_st     = ST_RELEASED;
          do_drop    = 1'b1;
          do_clr_ver = 1'b1;
          do_bump    = 1'b1;
          ok_c       = 1'b1;
        end
      end
      K_ABORT: begin
        act_ix = lix;
        if (le_ok && (st_r[lix] == ST_LEASED)) begin
          wr_st      = 1'b1;
          new_st     = ST_QUAR;
          do_drop    = 1'b1;
          do_clr_ver = 1'b1;
          do_bump    = 1'b1;
          ok_c       = 1'b1;
        end
      end
      K_QUERY: begin
        ok_c = eng_valid && le_ok && (tok_eng == eng_r) && (st_r[ix] == ST_LEASED);
      end
      K_REARM: begin
        if (eng_valid && (st_r[ix] == ST_QUAR)) begin
          wr_st      = 1'b1;
          new_st     = ST_DISABLED;
          do_clr_ver = 1'b1;
          do_bump    = 1'b1;
          ok_c       = 1'b1;
        end
      end
      K_READ: begin
        if (eng_valid) begin
          st_c = st_r[ix];
          ok_c = 1'b1;
        end
      end
      default: ok_c = 1'b0;
    endcase
  end

  // generation bump skips zero on wrap
  always_comb begin
    gen_inc = eng_gen_r[act_ix] + GenW'(1);
    if (gen_inc == '0) gen_inc = GenW'(1);
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind_t'(in_tuser);
      eng_r  <= in_tdata[7:0];
      ver_r  <= in_tdata[39:8];
      tok_r  <= in_tdata[103:40];
      own_r  <= in_tdata[135:104];
      rsv_r  <= in_tdata[167:136];
    end
  end

  // owner register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_id_r <= OwnerW'(1);
    end else if (cfg_we) begin
      owner_id_r <= cfg_wdata;
    end
  end

  // engine records and shared slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Engines; i++) begin
        st_r[i]        <= ST_DISABLED;
        eng_gen_r[i]   <= GenW'(i + 1);
        lease_gen_r[i] <= '0;
        id_ver_r[i]    <= '0;
      end
      slot_eng_r <= '0;
      slot_gen_r <= '0;
    end else if (cmd.commit) begin
      if (wr_st) st_r[act_ix] <= new_st;
      if (do_set_ver) id_ver_r[act_ix] <= ver_r;
      if (do_clr_ver) id_ver_r[act_ix] <= '0;
      if (do_bump) begin
        eng_gen_r[act_ix]   <= gen_inc;
        lease_gen_r[act_ix] <= '0;
      end
      if (do_acq) begin
        lease_gen_r[act_ix] <= eng_gen_r[act_ix];
        slot_eng_r          <= eng_r[2:0];
        slot_gen_r          <= eng_gen_r[act_ix];
      end
      if (do_drop && (slot_eng_r == {1'b0, act_ix} + 3'd1) &&
          (slot_gen_r == eng_gen_r[act_ix])) begin
        slot_eng_r <= '0;
        slot_gen_r <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok_r      <= ok_c;
      tok_out_r <= tok_c;
      own_out_r <= own_c;
      st_out_r  <= st_c;
    end
  end

  assign out_tdata = {4'b0, st_out_r, own_out_r, tok_out_r, ok_r};

endmodule

/* design/engine_lease_ownership_tracker.sv */
// Flow: an accepted beat is captured and the controller enters S_EXEC; the result is then
// registered and shown on out_t*. The controller holds one item at a time
// and the record update in the datapath commits only when the result register is free.
// A waiting result does not block the next input beat from being accepted.
// Reset (rst_n low, synchronous): all engines disabled, generations 1 to 4, owner_id 1,
// shared slot free, no result pending; in_tready rises in the cycle after release.
module engine_lease_ownership_tracker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [167:0] in_tdata,   // engine, version_word, lease_token, lease_owner, lease_reserved
  input  logic [2:0]   in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // ok, token_out, owner_out, eng_state, zero fill
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata   // owner_id
);
  import elot_pkg::*;

  elot_cmd_t cmd;

  // handshake controller
  elot_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // records and lease logic
  elot_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata)
  );

endmodule

/* design/elot_chk.sv */
// port-level checks for the engine lease ownership tracker
module elot_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // one item at a time: no input beat right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in flight");

  // a token appears only on success and carries magic and a shared-slot engine
  a_token_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[64:1] != 64'd0) |->
      out_tdata[0] && (out_tdata[64:41] == 24'hA54D) &&
      ((out_tdata[8:1] == 8'd1) || (out_tdata[8:1] == 8'd2)))
    else $error("malformed lease token");

  // a nonzero state is only reported by a successful read, with no token
  a_state_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[99:97] != 3'd0) |->
      out_tdata[0] && (out_tdata[64:1] == 64'd0) && (out_tdata[99:97] <= 3'd5))
    else $error("state reported outside a read");

endmodule

bind engine_lease_ownership_tracker elot_chk u_elot_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* verif/tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the engine lease ownership tracker
module tb;
  import elot_pkg::*;

  localparam int unsigned TimeoutCycles = 200000;
  localparam int unsigned HoldCycles    = 400;

  // fields of one result beat
  typedef struct packed {
    logic        ok;
    logic [63:0] tok;
    logic [31:0] owner;
    logic [2:0]  state;
  } lease_result_t;

  // shadow copy of the engine records, expected results and mismatch count
  class lease_scoreboard;
    logic [31:0]   owner_id;
    eng_state_t    st[Engines];
    logic [31:0]   gen[Engines];
    logic [31:0]   lgen[Engines];
    logic [31:0]   ver[Engines];
    logic [2:0]    slot_eng;
    logic [31:0]   slot_gen;
    lease_result_t pending_results[$];
    int unsigned   errors;
    int unsigned   results_seen;

    function new();
      owner_id = 32'd1;
      for (int i = 0; i < Engines; i++) begin
        st[i]   = ST_DISABLED;
        gen[i]  = 32'(i + 1);
        lgen[i] = '0;
        ver[i]  = '0;
      end
      slot_eng     = '0;
      slot_gen     = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // token that a fresh lease on engine e carries right now
    function logic [63:0] token_of(logic [7:0] e);
      return {TokMagic, gen[e - 1], e};
    endfunction

    function bit ver_rule_ok(logic [7:0] e, logic [31:0] v);
      case (e)
        8'd1: return v == Ver1Exact;
        8'd2: return (v & Ver2Mask) == Ver2Value;
        8'd4: return v[7:0] == Ver4LoA || v[7:0] == Ver4LoB;
        default: return 1'b0;
      endcase
    endfunction

    // new generation, skipping zero on wrap, drops the lease generation
    function void bump(int unsigned ix);
      gen[ix] = gen[ix] + 32'd1;
      if (gen[ix] == '0) gen[ix] = 32'd1;
      lgen[ix] = '0;
    endfunction

    // engine named by a valid presented lease, else 0
    function int unsigned lease_engine(logic [63:0] tok, logic [31:0] own, logic [31:0] rsv);
      int unsigned e;
      logic [31:0] g;
      e = 32'(tok[7:0]);
      g = tok[39:8];
      if (own == '0 || own != owner_id || rsv != '0) return 0;
      if (tok[63:40] != TokMagic) return 0;
      if (e < 1 || e > Engines || g == '0) return 0;
      if (gen[e - 1] != g || lgen[e - 1] != g) return 0;
      return e;
    endfunction

    // apply one accepted request and queue its result
    function void note_request(kind_t k, logic [167:0] d);
      logic [7:0]    e;
      logic [31:0]   v, own, rsv;
      logic [63:0]   tok;
      bit            inr;
      int unsigned   ix, le;
      lease_result_t r;
      e   = d[7:0];
      v   = d[39:8];
      tok = d[103:40];
      own = d[135:104];
      rsv = d[167:136];
      inr = e >= 1 && e <= Engines;
      ix  = inr ? e - 1 : 0;
      r   = '0;
      case (k)
        K_IDENT: begin
          if (inr && e != 8'd3 && (st[ix] == ST_DISABLED || st[ix] == ST_RELEASED)) begin
            if (ver_rule_ok(e, v)) begin
              ver[ix] = v;
              st[ix]  = ST_IDENT;
              r.ok    = 1'b1;
            end else begin
              ver[ix] = '0;
              bump(ix);
              st[ix] = ST_QUAR;
            end
          end
        end
        K_ACQUIRE: begin
          if (inr && (e == 8'd1 || e == 8'd2) && st[ix] == ST_IDENT && slot_eng == '0) begin
            slot_eng = e[2:0];
            slot_gen = gen[ix];
            lgen[ix] = gen[ix];
            st[ix]   = ST_LEASED;
            r.tok    = {TokMagic, gen[ix], e};
            r.owner  = owner_id;
            r.ok     = 1'b1;
          end
        end
        K_COMPLETE: begin
          le = lease_engine(tok, own, rsv);
          if (le != 0 && st[le - 1] == ST_LEASED) begin
            st[le - 1] = ST_DONE;
            r.ok = 1'b1;
          end
        end
        K_RELEASE, K_ABORT: begin
          le = lease_engine(tok, own, rsv);
          if (le != 0 && st[le - 1] == ((k == K_RELEASE) ? ST_DONE : ST_LEASED)) begin
            if (slot_eng == le && slot_gen == gen[le - 1]) begin
              slot_eng = '0;
              slot_gen = '0;
            end
            ver[le - 1] = '0;
            bump(le - 1);
            st[le - 1] = (k == K_RELEASE) ? ST_RELEASED : ST_QUAR;
            r.ok = 1'b1;
          end
        end
        K_QUERY: begin
          if (inr && lease_engine(tok, own, rsv) == e && st[ix] == ST_LEASED) r.ok = 1'b1;
        end
        K_REARM: begin
          if (inr && st[ix] == ST_QUAR) begin
            ver[ix] = '0;
            bump(ix);
            st[ix] = ST_DISABLED;
            r.ok   = 1'b1;
          end
        end
        default: begin
          if (inr) begin
            r.state = st[ix];
            r.ok    = 1'b1;
          end
        end
      endcase
      pending_results.push_back(r);
    endfunction

    task flag(string what, logic [63:0] got, logic [63:0] want);
      $display("result %0d %s: got %h, expected %h", results_seen, what, got, want);
      errors++;
    endtask

    // compare one result beat with the oldest expectation
    task check_reply(logic [103:0] d);
      lease_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        flag("unexpected beat", d[64:1], '0);
        return;
      end
      want = pending_results.pop_front();
      if (d[0] !== want.ok) flag("ok", 64'(d[0]), 64'(want.ok));
      if (d[64:1] !== want.tok) flag("token_out", d[64:1], want.tok);
      if (d[96:65] !== want.owner) flag("owner_out", 64'(d[96:65]), 64'(want.owner));
      if (d[99:97] !== want.state) flag("read state", 64'(d[99:97]), 64'(want.state));
      if (d[103:100] !== 4'h0) flag("zero fill", 64'(d[103:100]), '0);
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [167:0] in_tdata;   // engine, version_word, lease_token, lease_owner, lease_reserved
  logic [2:0]   in_tuser;   // kind
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;  // ok, token_out, owner_out, eng_state, zero fill
  logic         cfg_we;
  logic [31:0]  cfg_wdata;  // owner_id

  lease_scoreboard sb;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     cycle_count = 0;
  bit              recv_hold = 1'b0;

  engine_lease_ownership_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: check accepted beats, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reply(out_tdata);
    out_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TimeoutCycles) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [167:0] pack_in(logic [7:0] e, logic [31:0] v, logic [63:0] tok,
                                           logic [31:0] own, logic [31:0] rsv);
    return {rsv, own, tok, v, e};
  endfunction

  // offer one beat, with random idle cycles ahead of it
  task automatic send_item(kind_t k, logic [167:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(k, d);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_owner(logic [31:0] v);
    wait_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.owner_id = v;
  endtask

  // mostly legal lifecycle steps, some damaged leases, some raw noise
  task automatic send_random();
    logic [7:0]  e;
    logic [31:0] v, own, rsv;
    logic [63:0] tok;
    kind_t       k;
    int unsigned pick, sub;
    pick = $urandom_range(99);
    sub  = $urandom_range(9);
    e    = ($urandom_range(4) == 0) ? 8'($urandom_range(3, 4)) : 8'($urandom_range(1, 2));
    tok  = sb.token_of(e);
    own  = sb.owner_id;
    rsv  = '0;
    v    = $urandom;
    case (e)
      8'd1: v = Ver1Exact;
      8'd2: v = Ver2Value | 32'($urandom_range(15));
      8'd4: v[7:0] = $urandom_range(1) ? Ver4LoA : Ver4LoB;
      default: v = $urandom;
    endcase
    if (pick < 72) begin
      // next legal step for the engine's current record
      case (sb.st[e - 1])
        ST_DISABLED, ST_RELEASED: begin
          k = K_IDENT;
          if (sub == 0) v = $urandom;
        end
        ST_IDENT: k = (e <= 8'd2) ? K_ACQUIRE : ((sub < 5) ? K_QUERY : K_READ);
        ST_LEASED: k = (sub < 5) ? K_COMPLETE : ((sub < 7) ? K_ABORT : K_QUERY);
        ST_DONE: k = (sub < 8) ? K_RELEASE : K_QUERY;
        default: k = K_REARM;
      endcase
    end else if (pick < 90) begin
      // lease operation with at least one thing wrong
      k = kind_t'($urandom_range(K_COMPLETE, K_QUERY));
      case ($urandom_range(4))
        0: tok = tok ^ (64'd1 << $urandom_range(63));
        1: own = $urandom;
        2: rsv = 32'd1 << $urandom_range(31);
        3: tok[39:8] = tok[39:8] - 32'd1;
        default: begin
          own = '0;
          e   = e ^ 8'd3;
        end
      endcase
    end else begin
      k   = kind_t'($urandom_range(7));
      e   = 8'($urandom_range(255));
      v   = $urandom;
      tok = {$urandom, $urandom};
      own = $urandom;
      rsv = $urandom;
    end
    send_item(k, pack_in(e, v, tok, own, rsv));
  endtask

  task automatic run_phase(logic [31:0] owner, int unsigned sidle, int unsigned rstall,
                           int unsigned count, bit squeeze);
    write_owner(owner);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    // long receiver hold-off while requests keep coming
    if (squeeze) begin
      fork
        begin
          recv_hold = 1'b1;
          repeat (HoldCycles) @(posedge clk);
          recv_hold = 1'b0;
        end
      join_none
    end
    repeat (count) send_random();
  endtask

  initial begin
    logic [63:0] tok;
    sb = new();
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= K_IDENT;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: range edges, version rules, full lease lifecycles
    send_item(K_READ, pack_in(8'd0, '0, '0, '0, '0));
    send_item(K_READ, pack_in(8'd255, '0, '0, '0, '0));
    send_item(K_READ, pack_in(8'd1, '0, '0, '0, '0));
    send_item(K_IDENT, pack_in(8'd3, '0, '0, '0, '0));
    send_item(K_IDENT, pack_in(8'd4, 32'h0000_0055, '0, '0, '0));
    send_item(K_REARM, pack_in(8'd4, '0, '0, '0, '0));
    send_item(K_IDENT, pack_in(8'd4, 32'hFFFF_FF54, '0, '0, '0));
    send_item(K_IDENT, pack_in(8'd4, 32'h0000_0053, '0, '0, '0));
    send_item(K_ACQUIRE, pack_in(8'd4, '0, '0, '0, '0));
    send_item(K_IDENT, pack_in(8'd1, Ver1Exact, '0, '0, '0));
    send_item(K_IDENT, pack_in(8'd2, Ver2Value | 32'hF, '0, '0, '0));
    send_item(K_ACQUIRE, pack_in(8'd1, '0, '0, '0, '0));
    tok = sb.token_of(8'd1);
    send_item(K_ACQUIRE, pack_in(8'd2, '0, '0, '0, '0));
    send_item(K_QUERY, pack_in(8'd1, '0, tok, sb.owner_id, '0));
    send_item(K_QUERY, pack_in(8'd2, '0, tok, sb.owner_id, '0));
    send_item(K_COMPLETE, pack_in(8'd0, '0, tok, sb.owner_id, 32'd1));
    send_item(K_COMPLETE, pack_in(8'd0, '0, tok, '0, '0));
    send_item(K_COMPLETE, pack_in(8'd0, '0, tok ^ (64'd1 << 63), sb.owner_id, '0));
    send_item(K_RELEASE, pack_in(8'd0, '0, tok, sb.owner_id, '0));
    send_item(K_COMPLETE, pack_in(8'd0, '0, tok, sb.owner_id, '0));
    send_item(K_RELEASE, pack_in(8'd0, '0, tok, sb.owner_id, '0));
    send_item(K_ACQUIRE, pack_in(8'd2, '0, '0, '0, '0));
    send_item(K_ABORT, pack_in(8'd0, '0, sb.token_of(8'd2), sb.owner_id, '0));
    send_item(K_REARM, pack_in(8'd2, '0, '0, '0, '0));
    send_item(K_IDENT, pack_in(8'd1, Ver1Exact, '0, '0, '0));
    send_item(K_READ, pack_in(8'd4, '0, '0, '0, '0));

    // random phases over owner settings and flow-control mixes
    run_phase($urandom | 32'd1, 0, 0, 220, 1'b1);
    run_phase(32'hFFFF_FFFF, 87, 0, 180, 1'b0);
    run_phase(32'h0000_0000, 0, 87, 100, 1'b0);
    run_phase(32'h0000_0001, 24, 24, 220, 1'b0);
    run_phase($urandom | 32'h8000_0000, 0, 0, 200, 1'b0);

    wait_results();
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
